// ----- sv/significand_rounder_macros.svh -----
// Assertion macros for the significand rounder.
// Uses the clk and rst_n names of the including module.
`ifndef SIGNIFICAND_ROUNDER_MACROS_SVH
`define SIGNIFICAND_ROUNDER_MACROS_SVH

// same-cycle implication, checked out of reset
`define SR_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define SR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- sv/sigrnd_pkg.sv -----
// Package for the significand rounder: default widths, register indexes,
// rounding mode codes and the increment decision. No dependencies.
package sigrnd_pkg;

  localparam int SIG_WIDTH  = 64;
  localparam int EXP_WIDTH  = 16;
  localparam int PREC_W     = 7;
  localparam int CFG_ADDR_W = 3;

  localparam logic [PREC_W-1:0] MAX_PREC_RST = 7'd53;
  localparam int                MIN_EXP_RST  = -1074;

  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_USE_MAX_PREC = 3'd0,
    CFG_MAX_PREC     = 3'd1,
    CFG_USE_MIN_EXP  = 3'd2,
    CFG_MIN_EXP      = 3'd3,
    CFG_ROUND_MODE   = 3'd4
  } cfg_idx_t;

  typedef enum logic [2:0] {
    RM_RNE = 3'd0,
    RM_RNA = 3'd1,
    RM_RTP = 3'd2,
    RM_RTN = 3'd3,
    RM_RTZ = 3'd4,
    RM_RAZ = 3'd5,
    RM_RTO = 3'd6,
    RM_RTE = 3'd7
  } rnd_mode_t;

  function automatic logic wants_inc(rnd_mode_t mode, logic half, logic sticky,
                                     logic neg, logic odd);
    logic inx;
    logic r;
    inx = half | sticky;
    case (mode)
      RM_RNE:  r = half & (sticky | odd);
      RM_RNA:  r = half;
      RM_RTP:  r = inx & ~neg;
      RM_RTN:  r = inx & neg;
      RM_RTZ:  r = 1'b0;
      RM_RAZ:  r = inx;
      RM_RTO:  r = inx & ~odd;
      RM_RTE:  r = inx & odd;
      default: r = 1'b0;
    endcase
    return r;
  endfunction

endpackage

// ----- sv/significand_rounder.sv -----
// Significand rounder top level: four-stage rounding pipeline with config registers.
// Depends on sigrnd_pkg and significand_rounder_macros.svh.
//
// Rounds sign, integer significand and exponent to a precision limit, a lowest
// digit position, or both (the coarser of the two wins), in one of eight modes.
// The block takes one beat per cycle while not stalled; the stages find the bit length,
// then the cut position, then shift out the discarded digits with half and sticky bits,
// then increment and renormalize into the output register. All stages stall together
// while the output waits, so in_tready is low exactly when a result sits unaccepted with
// out_tready low. Write configuration only while no beat is in flight.
`include "significand_rounder_macros.svh"

module significand_rounder #(
  parameter int SIGNIFICAND_WIDTH = sigrnd_pkg::SIG_WIDTH,
  parameter int EXPONENT_WIDTH    = sigrnd_pkg::EXP_WIDTH
) (
  input  logic clk,
  input  logic rst_n,
  input  logic cfg_wen,
  input  logic [sigrnd_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [EXPONENT_WIDTH-1:0] cfg_wdata,
  input  logic in_tvalid,
  output logic in_tready,
  // sign_in, exponent_in, significand_in, zero fill
  input  logic [((SIGNIFICAND_WIDTH+EXPONENT_WIDTH+8)/8)*8-1:0] in_tdata,
  output logic out_tvalid,
  input  logic out_tready,
  // sign_out, exponent_out, significand_out, zero fill
  output logic [((SIGNIFICAND_WIDTH+EXPONENT_WIDTH+8)/8)*8-1:0] out_tdata,
  // inexact, exponent_out_of_range, param_error
  output logic [2:0] out_tuser
);
  import sigrnd_pkg::*;

  localparam int SW  = SIGNIFICAND_WIDTH;
  localparam int EW  = EXPONENT_WIDTH;
  localparam int XW  = EW + 2;
  localparam int BLW = $clog2(SW + 1);
  localparam int DW  = ((SW + EW + 8) / 8) * 8;

  logic en;

  logic              use_maxp_r;
  logic [PREC_W-1:0] maxp_r;
  logic              use_mine_r;
  logic [EW-1:0]     mine_r;
  rnd_mode_t         mode_r;
  logic [PREC_W-1:0] p_eff;

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      use_maxp_r <= 1'b1;
      maxp_r     <= MAX_PREC_RST;
      use_mine_r <= 1'b1;
      mine_r     <= EW'(MIN_EXP_RST);
      mode_r     <= RM_RNE;
    end else if (cfg_wen) begin
      case (cfg_idx_t'(cfg_addr))
        CFG_USE_MAX_PREC: use_maxp_r <= cfg_wdata[0];
        CFG_MAX_PREC:     maxp_r     <= cfg_wdata[PREC_W-1:0];
        CFG_USE_MIN_EXP:  use_mine_r <= cfg_wdata[0];
        CFG_MIN_EXP:      mine_r     <= cfg_wdata;
        CFG_ROUND_MODE:   mode_r     <= rnd_mode_t'(cfg_wdata[2:0]);
        default: ;
      endcase
    end
  end

  assign p_eff     = (maxp_r == '0) ? PREC_W'(1) : maxp_r;
  assign en        = !out_tvalid || out_tready;
  assign in_tready = en;

  // stage 1: bit length
  logic          in_sign;
  logic [EW-1:0] in_exp;
  logic [SW-1:0] in_sig;
  logic [BLW-1:0] in_bl;

  assign in_sign = in_tdata[0];
  assign in_exp  = in_tdata[EW:1];
  assign in_sig  = in_tdata[EW+SW:EW+1];

  always_comb begin
    in_bl = '0;
    for (int i = 0; i < SW; i++) begin
      if (in_sig[i]) in_bl = BLW'(i + 1);
    end
  end

  logic           s1_v_r;
  logic           s1_sign_r;
  logic [EW-1:0]  s1_exp_r;
  logic [SW-1:0]  s1_sig_r;
  logic [BLW-1:0] s1_bl_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (en) begin
      s1_v_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_sign_r <= in_sign;
      s1_exp_r  <= in_exp;
      s1_sig_r  <= in_sig;
      s1_bl_r   <= in_bl;
    end
  end

  // stage 2: cut position
  logic signed [XW-1:0] ex_x, mine_x, e_x, np_x, n_x, d_x;
  logic                 s2_perr_nxt, s2_disc_nxt;
  logic [BLW-1:0]       s2_hpos_nxt;

  always_comb begin
    ex_x   = XW'(signed'(s1_exp_r));
    mine_x = XW'(signed'(mine_r));
    e_x    = ex_x + signed'(XW'(s1_bl_r)) - signed'(XW'(1));
    np_x   = e_x - signed'(XW'(p_eff));
    if (use_maxp_r) begin
      n_x = (use_mine_r && (mine_x > np_x)) ? mine_x : np_x;
    end else begin
      n_x = mine_x;
    end
    d_x         = n_x - ex_x;
    s2_perr_nxt = !use_maxp_r && !use_mine_r;
    s2_disc_nxt = !s2_perr_nxt && ((s1_sig_r == '0) || !d_x[XW-1]);
    if (d_x[XW-1]) begin
      s2_hpos_nxt = '0;
    end else if (d_x >= signed'(XW'(SW))) begin
      s2_hpos_nxt = BLW'(SW);
    end else begin
      s2_hpos_nxt = d_x[BLW-1:0];
    end
  end

  logic                 s2_v_r;
  logic                 s2_sign_r;
  logic [EW-1:0]        s2_exp_r;
  logic [SW-1:0]        s2_sig_r;
  logic [BLW-1:0]       s2_hpos_r;
  logic signed [XW-1:0] s2_rexp_r;
  logic                 s2_disc_r;
  logic                 s2_perr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else if (en) begin
      s2_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_sign_r <= s1_sign_r;
      s2_exp_r  <= s1_exp_r;
      s2_sig_r  <= s1_sig_r;
      s2_hpos_r <= s2_hpos_nxt;
      s2_rexp_r <= n_x + signed'(XW'(1));
      s2_disc_r <= s2_disc_nxt;
      s2_perr_r <= s2_perr_nxt;
    end
  end

  // stage 3: discard digits
  logic [SW-1:0]        shifted, lowmask;
  logic [SW-1:0]        s3_kept_nxt;
  logic                 s3_half_nxt, s3_sticky_nxt;
  logic signed [XW-1:0] s3_rexp_nxt;

  always_comb begin
    shifted = s2_sig_r >> s2_hpos_r;
    lowmask = ~({SW{1'b1}} << s2_hpos_r);
    if (s2_disc_r) begin
      s3_kept_nxt   = shifted >> 1;
      s3_half_nxt   = shifted[0];
      s3_sticky_nxt = |(s2_sig_r & lowmask);
      s3_rexp_nxt   = s2_rexp_r;
    end else begin
      s3_kept_nxt   = s2_sig_r;
      s3_half_nxt   = 1'b0;
      s3_sticky_nxt = 1'b0;
      s3_rexp_nxt   = XW'(signed'(s2_exp_r));
    end
  end

  logic                 s3_v_r;
  logic                 s3_sign_r;
  logic [SW-1:0]        s3_kept_r;
  logic                 s3_half_r;
  logic                 s3_sticky_r;
  logic signed [XW-1:0] s3_rexp_r;
  logic                 s3_perr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_v_r <= 1'b0;
    end else if (en) begin
      s3_v_r <= s2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s3_sign_r   <= s2_sign_r;
      s3_kept_r   <= s3_kept_nxt;
      s3_half_r   <= s3_half_nxt;
      s3_sticky_r <= s3_sticky_nxt;
      s3_rexp_r   <= s3_rexp_nxt;
      s3_perr_r   <= s2_perr_r;
    end
  end

  // stage 4: increment and renormalize
  logic                 inc, ovf, oor;
  logic [SW-1:0]        kept_inc, sig_o;
  logic signed [XW-1:0] rexp_o;
  logic [XW-EW:0]       exp_top;

  always_comb begin
    inc      = wants_inc(mode_r, s3_half_r, s3_sticky_r, s3_sign_r, s3_kept_r[0]);
    kept_inc = s3_kept_r + SW'(inc);
    ovf      = inc && use_maxp_r && (|(kept_inc >> p_eff));
    sig_o    = ovf ? (kept_inc >> 1) : kept_inc;
    rexp_o   = s3_rexp_r + signed'(XW'(ovf));
    exp_top  = rexp_o[XW-1:EW-1];
    oor      = !((&exp_top) || !(|exp_top));
  end

  logic          out_v_r;
  logic [DW-1:0] out_data_r;
  logic [2:0]    out_user_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (en) begin
      out_v_r <= s3_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data_r <= DW'({sig_o, rexp_o[EW-1:0], s3_sign_r});
      out_user_r <= {s3_perr_r, oor, s3_half_r | s3_sticky_r};
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

  `SR_ASSERT_NOW(a_perr_clean, out_tvalid && out_tuser[2], !(|out_tuser[1:0]), "perr with flags")
  `SR_ASSERT_NOW(a_rtz_no_inc, s3_v_r && (mode_r == RM_RTZ), !inc, "increment under RTZ")
  `SR_ASSERT_NOW(a_ovf_exact, s3_v_r && ovf, inc && (s3_half_r || s3_sticky_r), "stray carry")
  `SR_ASSERT_NEXT(a_stall_hold, s3_v_r && !en, s3_v_r && $stable(s3_kept_r), "stall lost a beat")

endmodule
